FILE: rtl/ssd_pkg.sv
// ============================================================================
// ssd_pkg
// Shared widths, types and pipeline depths of the segment to segment
// closest distance pipeline.
// ============================================================================
package ssd_pkg;

    // coordinate and difference vectors
    localparam int COORD_W     = 16;
    localparam int DIFF_W      = COORD_W + 1;
    // dot products and their cross products
    localparam int DOT_W       = 2 * DIFF_W + 1;
    localparam int PROD_W      = 2 * DOT_W;
    // clamped numerators and denominators, always in [0, 2^68)
    localparam int DEN_W       = 68;
    // segment parameters carry 32 fraction bits, value in [0, 1]
    localparam int PARAM_FRAC  = 32;
    localparam int QUO_W       = PARAM_FRAC + 1;
    localparam int DIV_STEPS   = PARAM_FRAC + 1;
    localparam int DIV_LAT     = DIV_STEPS + 2;
    // parameter times direction, closest-approach vector
    localparam int MUL_W       = 50;
    localparam int DP_W        = MUL_W + 1;
    localparam int MAG_W       = DP_W - 1;
    localparam int HALF_W      = MAG_W / 2;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int SUM_W       = SQ_W + 2;
    // square root operand is the sum of squares scaled down by 2^62
    localparam int ROOT_LSB    = 2 * PARAM_FRAC - 2;
    localparam int ROOT_IN_W   = 39;
    localparam int ROOT_STEPS  = 20;
    localparam int ROOT_W      = 2 * ROOT_STEPS;
    // result fields
    localparam int OUT_W       = 18;
    localparam logic [OUT_W-1:0] DIST_MAX = '1;
    // pipeline depths
    localparam int GEO_DEPTH   = 6 + DIV_LAT + 1;
    localparam int LATENCY     = GEO_DEPTH + 5 + ROOT_STEPS;
    localparam int CLOSE_DEPTH = LATENCY - GEO_DEPTH;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [DOT_W-1:0]   dot_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic        [DEN_W-1:0]   den_t;
    typedef logic        [QUO_W-1:0]   quo_t;
    typedef logic signed [MUL_W-1:0]   mul_t;
    typedef logic signed [DP_W-1:0]    dp_t;
    typedef logic        [MAG_W-1:0]   mag_t;
    typedef logic        [HALF_W-1:0]  half_t;
    typedef logic        [SQ_W-1:0]    sq_t;
    typedef logic        [SUM_W-1:0]   sum_t;
    typedef logic        [ROOT_W-1:0]  root_t;
    typedef logic signed [OUT_W-1:0]   out_t;

    typedef struct packed {
        dot_t a;
        dot_t b;
        dot_t c;
        dot_t d;
        dot_t e;
    } dots_t;

endpackage

FILE: rtl/ssd_div.sv
// ============================================================================
// ssd_div
// Pipelined restoring divider, one quotient bit per stage. Returns
// num/den rounded to nearest with 32 fraction bits for 0 <= num <= den,
// and zero when either operand is zero.
// ============================================================================
module ssd_div (
    input  logic          clk,
    input  ssd_pkg::den_t num,
    input  ssd_pkg::den_t den,
    output ssd_pkg::quo_t quo
);

    typedef struct packed {
        ssd_pkg::den_t rem;
        ssd_pkg::den_t den;
        ssd_pkg::quo_t q;
        logic          zero;
        logic          full;
    } div_stage_t;

    div_stage_t    st_reg  [ssd_pkg::DIV_STEPS+1];
    div_stage_t    st_next [ssd_pkg::DIV_STEPS+1];
    ssd_pkg::quo_t quo_reg;
    ssd_pkg::quo_t quo_next;

    always_comb
    begin
        logic [ssd_pkg::DEN_W:0]   dbl;
        logic [ssd_pkg::DEN_W:0]   sub;
        logic                      ge;
        logic [ssd_pkg::QUO_W:0]   inc;

        // entry: remainder starts at the numerator
        st_next[0].rem  = num;
        st_next[0].den  = den;
        st_next[0].q    = '0;
        st_next[0].zero = (num == '0) || (den == '0);
        st_next[0].full = (num == den);

        // one bit of floor(num * 2^33 / den) per stage
        for (int k = 0; k < ssd_pkg::DIV_STEPS; k++)
        begin
            dbl = {st_reg[k].rem, 1'b0};
            sub = dbl - {1'b0, st_reg[k].den};
            ge  = (dbl >= {1'b0, st_reg[k].den});
            st_next[k+1].rem  = ge ? sub[ssd_pkg::DEN_W-1:0] : dbl[ssd_pkg::DEN_W-1:0];
            st_next[k+1].den  = st_reg[k].den;
            st_next[k+1].q    = {st_reg[k].q[ssd_pkg::QUO_W-2:0], ge};
            st_next[k+1].zero = st_reg[k].zero;
            st_next[k+1].full = st_reg[k].full;
        end

        // halve with rounding, ties upward
        inc = {1'b0, st_reg[ssd_pkg::DIV_STEPS].q} + 1'b1;
        priority if (st_reg[ssd_pkg::DIV_STEPS].zero)
            quo_next = '0;
        else if (st_reg[ssd_pkg::DIV_STEPS].full)
            quo_next = ssd_pkg::quo_t'(1) << ssd_pkg::PARAM_FRAC;
        else
            quo_next = inc[ssd_pkg::QUO_W:1];
    end

    always_ff @(posedge clk)
    begin
        st_reg  <= st_next;
        quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule

FILE: rtl/segment_segment_closest_distance.sv
// ============================================================================
// segment_segment_closest_distance
// Shortest distance between two 3D segments with Q8.8 ends, as unsigned Q10.8, with
// the offset of the closest point along the second segment as signed Q10.8.
// ============================================================================
// pipeline: 67 register stages, and done rises with the result of each accepted
//   query; the longest path is the two 33-step dividers side by side
//   followed by the 20-step square root
// throughput: one transaction per cycle, busy is never raised
// reset: rst_n clears the valid pipeline only, no result leaves after reset
// the receiver cannot stall, results are shown for one cycle with done
module segment_segment_closest_distance (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  ssd_pkg::coord_t             first_start_x,
    input  ssd_pkg::coord_t             first_start_y,
    input  ssd_pkg::coord_t             first_start_z,
    input  ssd_pkg::coord_t             first_end_x,
    input  ssd_pkg::coord_t             first_end_y,
    input  ssd_pkg::coord_t             first_end_z,
    input  ssd_pkg::coord_t             second_start_x,
    input  ssd_pkg::coord_t             second_start_y,
    input  ssd_pkg::coord_t             second_start_z,
    input  ssd_pkg::coord_t             second_end_x,
    input  ssd_pkg::coord_t             second_end_y,
    input  ssd_pkg::coord_t             second_end_z,
    output logic                        done,
    output logic [ssd_pkg::OUT_W-1:0]   distance,
    output ssd_pkg::out_t               closest_x,
    output ssd_pkg::out_t               closest_y,
    output ssd_pkg::out_t               closest_z
);

    // ------------------------------------------------------------------
    // handshake and valid pipeline
    // ------------------------------------------------------------------
    logic                          accept;
    logic [ssd_pkg::LATENCY-1:0]   vld_reg;
    logic [ssd_pkg::LATENCY-1:0]   vld_next;

    assign busy     = 1'b0;
    assign accept   = start & ~busy;
    assign vld_next = {vld_reg[ssd_pkg::LATENCY-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign done = vld_reg[ssd_pkg::LATENCY-1];

    // ------------------------------------------------------------------
    // stage 1: direction vectors u, v and offset w; the vectors then ride
    // along until the closest-approach vector is formed
    // ------------------------------------------------------------------
    ssd_pkg::diff_t u_reg  [ssd_pkg::GEO_DEPTH][3];
    ssd_pkg::diff_t v_reg  [ssd_pkg::GEO_DEPTH][3];
    ssd_pkg::diff_t w_reg  [ssd_pkg::GEO_DEPTH][3];
    ssd_pkg::diff_t u_next [ssd_pkg::GEO_DEPTH][3];
    ssd_pkg::diff_t v_next [ssd_pkg::GEO_DEPTH][3];
    ssd_pkg::diff_t w_next [ssd_pkg::GEO_DEPTH][3];

    always_comb
    begin
        u_next[0][0] = ssd_pkg::diff_t'(first_end_x) - ssd_pkg::diff_t'(first_start_x);
        u_next[0][1] = ssd_pkg::diff_t'(first_end_y) - ssd_pkg::diff_t'(first_start_y);
        u_next[0][2] = ssd_pkg::diff_t'(first_end_z) - ssd_pkg::diff_t'(first_start_z);
        v_next[0][0] = ssd_pkg::diff_t'(second_end_x) - ssd_pkg::diff_t'(second_start_x);
        v_next[0][1] = ssd_pkg::diff_t'(second_end_y) - ssd_pkg::diff_t'(second_start_y);
        v_next[0][2] = ssd_pkg::diff_t'(second_end_z) - ssd_pkg::diff_t'(second_start_z);
        w_next[0][0] = ssd_pkg::diff_t'(first_start_x) - ssd_pkg::diff_t'(second_start_x);
        w_next[0][1] = ssd_pkg::diff_t'(first_start_y) - ssd_pkg::diff_t'(second_start_y);
        w_next[0][2] = ssd_pkg::diff_t'(first_start_z) - ssd_pkg::diff_t'(second_start_z);
        for (int k = 1; k < ssd_pkg::GEO_DEPTH; k++)
        begin
            u_next[k] = u_reg[k-1];
            v_next[k] = v_reg[k-1];
            w_next[k] = w_reg[k-1];
        end
    end

    // ------------------------------------------------------------------
    // stage 2: dot products a=u.u b=u.v c=v.v d=u.w e=v.w
    // ------------------------------------------------------------------
    function automatic ssd_pkg::dot_t dot3(input ssd_pkg::diff_t x [3],
                                           input ssd_pkg::diff_t y [3]);
        return ssd_pkg::dot_t'(x[0]) * ssd_pkg::dot_t'(y[0])
             + ssd_pkg::dot_t'(x[1]) * ssd_pkg::dot_t'(y[1])
             + ssd_pkg::dot_t'(x[2]) * ssd_pkg::dot_t'(y[2]);
    endfunction

    ssd_pkg::dots_t dot2_reg, dot3_reg, dot4_reg, dot5_reg;
    ssd_pkg::dots_t dot2_next;

    always_comb
    begin
        dot2_next.a = dot3(u_reg[0], u_reg[0]);
        dot2_next.b = dot3(u_reg[0], v_reg[0]);
        dot2_next.c = dot3(v_reg[0], v_reg[0]);
        dot2_next.d = dot3(u_reg[0], w_reg[0]);
        dot2_next.e = dot3(v_reg[0], w_reg[0]);
    end

    // ------------------------------------------------------------------
    // stage 3: cross products of the dot products
    // ------------------------------------------------------------------
    ssd_pkg::prod_t ac_reg, bb_reg, be_reg, cd_reg, ae_reg, bd_reg;
    ssd_pkg::prod_t ac_next, bb_next, be_next, cd_next, ae_next, bd_next;

    always_comb
    begin
        ac_next = ssd_pkg::prod_t'(dot2_reg.a) * ssd_pkg::prod_t'(dot2_reg.c);
        bb_next = ssd_pkg::prod_t'(dot2_reg.b) * ssd_pkg::prod_t'(dot2_reg.b);
        be_next = ssd_pkg::prod_t'(dot2_reg.b) * ssd_pkg::prod_t'(dot2_reg.e);
        cd_next = ssd_pkg::prod_t'(dot2_reg.c) * ssd_pkg::prod_t'(dot2_reg.d);
        ae_next = ssd_pkg::prod_t'(dot2_reg.a) * ssd_pkg::prod_t'(dot2_reg.e);
        bd_next = ssd_pkg::prod_t'(dot2_reg.b) * ssd_pkg::prod_t'(dot2_reg.d);
    end

    // ------------------------------------------------------------------
    // stage 4: determinant and raw numerators
    // ------------------------------------------------------------------
    ssd_pkg::prod_t det_reg, sn0_reg, tn0_reg;
    ssd_pkg::prod_t det_next, sn0_next, tn0_next;

    assign det_next = ac_reg - bb_reg;
    assign sn0_next = be_reg - cd_reg;
    assign tn0_next = ae_reg - bd_reg;

    // ------------------------------------------------------------------
    // stage 5: parallel case and clamp of s to the first segment's ends
    // ------------------------------------------------------------------
    ssd_pkg::prod_t sn5_reg, sd5_reg, tn5_reg, td5_reg;
    ssd_pkg::prod_t sn5_next, sd5_next, tn5_next, td5_next;

    always_comb
    begin
        priority if (det_reg <= ssd_pkg::prod_t'(0))
        begin
            // parallel segments: s fixed at the start
            sn5_next = '0;
            sd5_next = ssd_pkg::prod_t'(1);
            tn5_next = ssd_pkg::prod_t'(dot4_reg.e);
            td5_next = ssd_pkg::prod_t'(dot4_reg.c);
        end
        else if (sn0_reg < ssd_pkg::prod_t'(0))
        begin
            sn5_next = '0;
            sd5_next = det_reg;
            tn5_next = ssd_pkg::prod_t'(dot4_reg.e);
            td5_next = ssd_pkg::prod_t'(dot4_reg.c);
        end
        else if (sn0_reg > det_reg)
        begin
            sn5_next = det_reg;
            sd5_next = det_reg;
            tn5_next = ssd_pkg::prod_t'(dot4_reg.e) + ssd_pkg::prod_t'(dot4_reg.b);
            td5_next = ssd_pkg::prod_t'(dot4_reg.c);
        end
        else
        begin
            sn5_next = sn0_reg;
            sd5_next = det_reg;
            tn5_next = tn0_reg;
            td5_next = det_reg;
        end
    end

    // ------------------------------------------------------------------
    // stage 6: clamp of t to the second segment's ends, s solved again
    // ------------------------------------------------------------------
    ssd_pkg::den_t ns_reg, ds_reg, nt_reg, dt_reg;
    ssd_pkg::den_t ns_next, ds_next, nt_next, dt_next;

    always_comb
    begin
        ssd_pkg::prod_t m;
        ssd_pkg::prod_t sn;
        ssd_pkg::prod_t sd;
        ssd_pkg::prod_t tn;
        logic           t_lo;
        logic           t_hi;

        t_lo = (tn5_reg < ssd_pkg::prod_t'(0));
        t_hi = (tn5_reg > td5_reg);
        sn   = sn5_reg;
        sd   = sd5_reg;
        tn   = tn5_reg;
        m    = t_lo ? -ssd_pkg::prod_t'(dot5_reg.d)
                    : ssd_pkg::prod_t'(dot5_reg.b) - ssd_pkg::prod_t'(dot5_reg.d);
        if (t_lo || t_hi)
        begin
            tn = t_lo ? '0 : td5_reg;
            priority if (m < ssd_pkg::prod_t'(0))
                sn = '0;
            else if (m > ssd_pkg::prod_t'(dot5_reg.a))
                sn = sd5_reg;
            else
            begin
                sn = m;
                sd = ssd_pkg::prod_t'(dot5_reg.a);
            end
        end
        // every numerator now lies between zero and its denominator
        ns_next = sn[ssd_pkg::DEN_W-1:0];
        ds_next = sd[ssd_pkg::DEN_W-1:0];
        nt_next = tn[ssd_pkg::DEN_W-1:0];
        dt_next = td5_reg[ssd_pkg::DEN_W-1:0];
    end

    // ------------------------------------------------------------------
    // stages 7..41: the two parameter dividers side by side
    // ------------------------------------------------------------------
    ssd_pkg::quo_t sc_q;
    ssd_pkg::quo_t tc_q;

    ssd_div u_div_s (
        .clk (clk),
        .num (ns_reg),
        .den (ds_reg),
        .quo (sc_q)
    );

    ssd_div u_div_t (
        .clk (clk),
        .num (nt_reg),
        .den (dt_reg),
        .quo (tc_q)
    );

    // ------------------------------------------------------------------
    // stage 42: sc*u and tc*v
    // ------------------------------------------------------------------
    ssd_pkg::mul_t scu_reg [3];
    ssd_pkg::mul_t tv_reg  [3];
    ssd_pkg::mul_t scu_next [3];
    ssd_pkg::mul_t tv_next  [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            scu_next[i] = ssd_pkg::mul_t'(signed'({1'b0, sc_q}))
                        * ssd_pkg::mul_t'(u_reg[ssd_pkg::GEO_DEPTH-2][i]);
            tv_next[i]  = ssd_pkg::mul_t'(signed'({1'b0, tc_q}))
                        * ssd_pkg::mul_t'(v_reg[ssd_pkg::GEO_DEPTH-2][i]);
        end
    end

    // ------------------------------------------------------------------
    // stage 43: closest-approach vector and rounded offset along v
    // ------------------------------------------------------------------
    ssd_pkg::dp_t  dp_reg  [3];
    ssd_pkg::dp_t  dp_next [3];
    ssd_pkg::out_t close_reg  [ssd_pkg::CLOSE_DEPTH][3];
    ssd_pkg::out_t close_next [ssd_pkg::CLOSE_DEPTH][3];

    always_comb
    begin
        ssd_pkg::mul_t rnd;

        for (int i = 0; i < 3; i++)
        begin
            dp_next[i] = (ssd_pkg::dp_t'(w_reg[ssd_pkg::GEO_DEPTH-1][i]) <<< ssd_pkg::PARAM_FRAC)
                       + ssd_pkg::dp_t'(scu_reg[i]) - ssd_pkg::dp_t'(tv_reg[i]);
            // round half up; the offset never leaves the output range
            rnd = tv_reg[i] + (ssd_pkg::mul_t'(1) <<< (ssd_pkg::PARAM_FRAC - 1));
            close_next[0][i] = rnd[ssd_pkg::MUL_W-1:ssd_pkg::PARAM_FRAC];
        end
        for (int k = 1; k < ssd_pkg::CLOSE_DEPTH; k++)
            close_next[k] = close_reg[k-1];
    end

    // ------------------------------------------------------------------
    // stage 44: squares split into 25-bit halves
    // ------------------------------------------------------------------
    ssd_pkg::mag_t hh_reg [3], hl_reg [3], ll_reg [3];
    ssd_pkg::mag_t hh_next [3], hl_next [3], ll_next [3];

    always_comb
    begin
        ssd_pkg::mag_t  mag;
        ssd_pkg::half_t hi;
        ssd_pkg::half_t lo;

        for (int i = 0; i < 3; i++)
        begin
            mag = dp_reg[i][ssd_pkg::DP_W-1] ? ssd_pkg::mag_t'(-dp_reg[i])
                                             : ssd_pkg::mag_t'(dp_reg[i]);
            hi  = mag[ssd_pkg::MAG_W-1:ssd_pkg::HALF_W];
            lo  = mag[ssd_pkg::HALF_W-1:0];
            hh_next[i] = ssd_pkg::mag_t'(hi) * ssd_pkg::mag_t'(hi);
            hl_next[i] = ssd_pkg::mag_t'(hi) * ssd_pkg::mag_t'(lo);
            ll_next[i] = ssd_pkg::mag_t'(lo) * ssd_pkg::mag_t'(lo);
        end
    end

    // ------------------------------------------------------------------
    // stage 45: recombined squares
    // ------------------------------------------------------------------
    ssd_pkg::sq_t sq_reg  [3];
    ssd_pkg::sq_t sq_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            sq_next[i] = (ssd_pkg::sq_t'(hh_reg[i]) << (2 * ssd_pkg::HALF_W))
                       + (ssd_pkg::sq_t'(hl_reg[i]) << (ssd_pkg::HALF_W + 1))
                       + ssd_pkg::sq_t'(ll_reg[i]);
    end

    // ------------------------------------------------------------------
    // stage 46..66: sum of squares, then an integer square root one bit
    // per stage; round(sqrt(s) / 2^32) = (isqrt(s >> 62) + 1) >> 1
    // ------------------------------------------------------------------
    ssd_pkg::root_t rt_op_reg   [ssd_pkg::ROOT_STEPS+1];
    ssd_pkg::root_t rt_res_reg  [ssd_pkg::ROOT_STEPS+1];
    ssd_pkg::root_t rt_op_next  [ssd_pkg::ROOT_STEPS+1];
    ssd_pkg::root_t rt_res_next [ssd_pkg::ROOT_STEPS+1];

    always_comb
    begin
        ssd_pkg::sum_t  sum;
        ssd_pkg::root_t one;
        ssd_pkg::root_t trial;

        sum = ssd_pkg::sum_t'(sq_reg[0]) + ssd_pkg::sum_t'(sq_reg[1])
            + ssd_pkg::sum_t'(sq_reg[2]);
        rt_op_next[0]  = ssd_pkg::root_t'(
            sum[ssd_pkg::ROOT_LSB+ssd_pkg::ROOT_IN_W-1:ssd_pkg::ROOT_LSB]);
        rt_res_next[0] = '0;
        for (int j = 0; j < ssd_pkg::ROOT_STEPS; j++)
        begin
            one   = ssd_pkg::root_t'(1) << (2 * (ssd_pkg::ROOT_STEPS - 1 - j));
            trial = rt_res_reg[j] + one;
            if (rt_op_reg[j] >= trial)
            begin
                rt_op_next[j+1]  = rt_op_reg[j] - trial;
                rt_res_next[j+1] = (rt_res_reg[j] >> 1) + one;
            end
            else
            begin
                rt_op_next[j+1]  = rt_op_reg[j];
                rt_res_next[j+1] = rt_res_reg[j] >> 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 67: rounding and saturation of the distance
    // ------------------------------------------------------------------
    logic [ssd_pkg::OUT_W-1:0] distance_reg;
    logic [ssd_pkg::OUT_W-1:0] distance_next;

    always_comb
    begin
        logic [ssd_pkg::ROOT_STEPS:0] inc;

        inc = {1'b0, rt_res_reg[ssd_pkg::ROOT_STEPS][ssd_pkg::ROOT_STEPS-1:0]} + 1'b1;
        if (inc[ssd_pkg::ROOT_STEPS:ssd_pkg::OUT_W+1] != '0)
            distance_next = ssd_pkg::DIST_MAX;
        else
            distance_next = inc[ssd_pkg::OUT_W:1];
    end

    // ------------------------------------------------------------------
    // datapath registers, no reset
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        u_reg        <= u_next;
        v_reg        <= v_next;
        w_reg        <= w_next;
        dot2_reg     <= dot2_next;
        dot3_reg     <= dot2_reg;
        dot4_reg     <= dot3_reg;
        dot5_reg     <= dot4_reg;
        ac_reg       <= ac_next;
        bb_reg       <= bb_next;
        be_reg       <= be_next;
        cd_reg       <= cd_next;
        ae_reg       <= ae_next;
        bd_reg       <= bd_next;
        det_reg      <= det_next;
        sn0_reg      <= sn0_next;
        tn0_reg      <= tn0_next;
        sn5_reg      <= sn5_next;
        sd5_reg      <= sd5_next;
        tn5_reg      <= tn5_next;
        td5_reg      <= td5_next;
        ns_reg       <= ns_next;
        ds_reg       <= ds_next;
        nt_reg       <= nt_next;
        dt_reg       <= dt_next;
        scu_reg      <= scu_next;
        tv_reg       <= tv_next;
        dp_reg       <= dp_next;
        close_reg    <= close_next;
        hh_reg       <= hh_next;
        hl_reg       <= hl_next;
        ll_reg       <= ll_next;
        sq_reg       <= sq_next;
        rt_op_reg    <= rt_op_next;
        rt_res_reg   <= rt_res_next;
        distance_reg <= distance_next;
    end

    assign distance  = distance_reg;
    assign closest_x = close_reg[ssd_pkg::CLOSE_DEPTH-1][0];
    assign closest_y = close_reg[ssd_pkg::CLOSE_DEPTH-1][1];
    assign closest_z = close_reg[ssd_pkg::CLOSE_DEPTH-1][2];

endmodule

FILE: rtl/ssd_chk.sv
// ============================================================================
// ssd_chk
// Port-level checks of the closest distance pipeline: fixed latency and
// known results for coincident segments and a point second segment.
// ============================================================================
module ssd_chk (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      start,
    input logic                      busy,
    input ssd_pkg::coord_t           first_start_x,
    input ssd_pkg::coord_t           first_start_y,
    input ssd_pkg::coord_t           first_start_z,
    input ssd_pkg::coord_t           first_end_x,
    input ssd_pkg::coord_t           first_end_y,
    input ssd_pkg::coord_t           first_end_z,
    input ssd_pkg::coord_t           second_start_x,
    input ssd_pkg::coord_t           second_start_y,
    input ssd_pkg::coord_t           second_start_z,
    input ssd_pkg::coord_t           second_end_x,
    input ssd_pkg::coord_t           second_end_y,
    input ssd_pkg::coord_t           second_end_z,
    input logic                      done,
    input logic [ssd_pkg::OUT_W-1:0] distance,
    input ssd_pkg::out_t             closest_x,
    input ssd_pkg::out_t             closest_y,
    input ssd_pkg::out_t             closest_z
);

    logic same_seg;
    logic point_second;

    assign same_seg = (first_start_x == second_start_x) && (first_start_y == second_start_y)
                   && (first_start_z == second_start_z) && (first_end_x == second_end_x)
                   && (first_end_y == second_end_y) && (first_end_z == second_end_z);

    assign point_second = (second_start_x == second_end_x) && (second_start_y == second_end_y)
                       && (second_start_z == second_end_z);

    // every transaction comes back after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##(ssd_pkg::LATENCY) done)
        else $error("result missing after fixed latency");

    // no result without a transaction the same latency earlier
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, ssd_pkg::LATENCY))
        else $error("result without matching transaction");

    // a segment is at zero distance from itself
    a_same_zero: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && same_seg |-> ##(ssd_pkg::LATENCY) (distance == '0))
        else $error("coincident segments gave nonzero distance");

    // a point second segment has no offset along it
    a_point_offset: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && point_second |-> ##(ssd_pkg::LATENCY)
            (closest_x == '0 && closest_y == '0 && closest_z == '0))
        else $error("nonzero offset along a point segment");

endmodule

bind segment_segment_closest_distance ssd_chk u_ssd_chk (.*);

FILE: sim/tb_segment_segment_closest_distance.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_segment_segment_closest_distance
// Self-checking bench for the segment to segment closest distance pipeline.
// Queries are sent in bursts with random gaps. An exact wide-integer
// predictor works out the distance and the tc*v offset for each accepted
// query. Every strobed result is compared with the oldest prediction.
// ============================================================================
module tb_segment_segment_closest_distance;

    localparam int CLK_HALF   = 2;
    localparam int RESET_CYC  = 7;
    localparam int N_RANDOM   = 1500;
    localparam int IDLE_LIMIT = 4 * ssd_pkg::LATENCY + 200;
    localparam int MAX_PRINTS = 40;

    // exact arithmetic is done on wide signed vectors, far beyond any
    // intermediate width the algorithm needs
    typedef logic signed [255:0] wide_t;

    // one query: 12 coordinates in the order fs xyz, fe xyz, ss xyz, se xyz
    typedef struct {
        ssd_pkg::coord_t pt[12];
    } query_t;

    typedef struct {
        logic [ssd_pkg::OUT_W-1:0] dist_val;
        ssd_pkg::out_t             cx;
        ssd_pkg::out_t             cy;
        ssd_pkg::out_t             cz;
    } answer_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    ssd_pkg::coord_t fsx, fsy, fsz, fex, fey, fez;
    ssd_pkg::coord_t ssx, ssy, ssz, sex, sey, sez;
    logic done;
    logic [ssd_pkg::OUT_W-1:0] distance;
    ssd_pkg::out_t closest_x, closest_y, closest_z;

    int fail_count = 0;
    int printed    = 0;

    // ------------------------------------------------------------------------
    // scoreboard: predicts each accepted transaction, checks each result
    // ------------------------------------------------------------------------
    class distance_scoreboard;
        answer_t pending_q[$];
        int      noted   = 0;
        int      checked = 0;

        // round(n/dn) with PARAM_FRAC fraction bits, 0 unless both positive
        function wide_t param_ratio(wide_t n, wide_t dn);
            wide_t q;
            if (n <= 0 || dn <= 0)
                return 0;
            q = ((n <<< (ssd_pkg::PARAM_FRAC + 1)) + dn) / (dn <<< 1);
            if (q > (wide_t'(1) <<< ssd_pkg::PARAM_FRAC))
                q = wide_t'(1) <<< ssd_pkg::PARAM_FRAC;
            return q;
        endfunction

        function wide_t clamp(wide_t x, wide_t lo, wide_t hi);
            if (x < lo)
                return lo;
            if (x > hi)
                return hi;
            return x;
        endfunction

        function answer_t predict(query_t q);
            wide_t u[3], v[3], w[3];
            wide_t a, b, c, d, e, det, s_num, s_den, t_num, t_den, m;
            wide_t sc, tc, tv, dp, sum_sq, root, cand, rnd;
            answer_t ans;
            sum_sq = 0;
            for (int i = 0; i < 3; i++)
            begin
                u[i] = wide_t'(q.pt[3 + i]) - wide_t'(q.pt[i]);
                v[i] = wide_t'(q.pt[9 + i]) - wide_t'(q.pt[6 + i]);
                w[i] = wide_t'(q.pt[i]) - wide_t'(q.pt[6 + i]);
            end
            a = u[0] * u[0] + u[1] * u[1] + u[2] * u[2];
            b = u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
            c = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
            d = u[0] * w[0] + u[1] * w[1] + u[2] * w[2];
            e = v[0] * w[0] + v[1] * w[1] + v[2] * w[2];
            det = a * c - b * b;
            s_den = det;
            t_den = det;
            // parallel: pin s to the first start, solve t alone
            if (det <= 0)
            begin
                s_num = 0;
                s_den = 1;
                t_num = e;
                t_den = c;
            end
            else
            begin
                s_num = b * e - c * d;
                t_num = a * e - b * d;
                if (s_num < 0)
                begin
                    s_num = 0;
                    t_num = e;
                    t_den = c;
                end
                else if (s_num > s_den)
                begin
                    s_num = s_den;
                    t_num = e + b;
                    t_den = c;
                end
            end
            // t off either end: clamp it and solve s again
            if (t_num < 0 || t_num > t_den)
            begin
                if (t_num < 0)
                begin
                    t_num = 0;
                    m = -d;
                end
                else
                begin
                    t_num = t_den;
                    m = b - d;
                end
                if (m < 0)
                    s_num = 0;
                else if (m > a)
                    s_num = s_den;
                else
                begin
                    s_num = m;
                    s_den = a;
                end
            end
            sc = param_ratio(s_num, s_den);
            tc = param_ratio(t_num, t_den);
            for (int i = 0; i < 3; i++)
            begin
                tv  = tc * v[i];
                rnd = clamp((tv + (wide_t'(1) <<< (ssd_pkg::PARAM_FRAC - 1)))
                            >>> ssd_pkg::PARAM_FRAC, -131072, 131071);
                if (i == 0) ans.cx = rnd[ssd_pkg::OUT_W-1:0];
                if (i == 1) ans.cy = rnd[ssd_pkg::OUT_W-1:0];
                if (i == 2) ans.cz = rnd[ssd_pkg::OUT_W-1:0];
                dp = (w[i] <<< ssd_pkg::PARAM_FRAC) + sc * u[i] - tv;
                sum_sq = sum_sq + dp * dp;
            end
            // floor(sqrt(4*sum)), then round at the input lsb
            sum_sq = sum_sq <<< 2;
            root = 0;
            for (int bit_i = 72; bit_i >= 0; bit_i--)
            begin
                cand = root + (wide_t'(1) <<< bit_i);
                if (cand * cand <= sum_sq)
                    root = cand;
            end
            root = (root + (wide_t'(1) <<< ssd_pkg::PARAM_FRAC)) >>> (ssd_pkg::PARAM_FRAC + 1);
            root = clamp(root, 0, 262143);
            ans.dist_val = root[ssd_pkg::OUT_W-1:0];
            return ans;
        endfunction

        function void note(query_t q);
            pending_q.push_back(predict(q));
            noted++;
        endfunction

        task report(string what, int got, int want);
            fail_count++;
            if (printed < MAX_PRINTS)
            begin
                $display("mismatch on result %0d: %s got %0d expected %0d",
                         checked, what, got, want);
                printed++;
            end
        endtask

        task check(answer_t got);
            answer_t want;
            if (pending_q.size() == 0)
            begin
                report("unexpected result, distance", got.dist_val, -1);
                return;
            end
            want = pending_q.pop_front();
            if (got.dist_val !== want.dist_val) report("distance", got.dist_val, want.dist_val);
            if (got.cx !== want.cx) report("closest_x", got.cx, want.cx);
            if (got.cy !== want.cy) report("closest_y", got.cy, want.cy);
            if (got.cz !== want.cz) report("closest_z", got.cz, want.cz);
            checked++;
        endtask

        function int outstanding();
            return pending_q.size();
        endfunction
    endclass

    distance_scoreboard sb = new();

    segment_segment_closest_distance dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .first_start_x  (fsx),
        .first_start_y  (fsy),
        .first_start_z  (fsz),
        .first_end_x    (fex),
        .first_end_y    (fey),
        .first_end_z    (fez),
        .second_start_x (ssx),
        .second_start_y (ssy),
        .second_start_z (ssz),
        .second_end_x   (sex),
        .second_end_y   (sey),
        .second_end_z   (sez),
        .done           (done),
        .distance       (distance),
        .closest_x      (closest_x),
        .closest_y      (closest_y),
        .closest_z      (closest_z)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #CLK_HALF clk = ~clk;
        end
    end

    // outputs are sampled mid-cycle so no edge ordering matters
    logic busy_s = 1'b0;
    int   idle_cycles = 0;

    always @(negedge clk)
    begin
        answer_t got;
        busy_s <= busy;
        if (rst_n && done)
        begin
            got.dist_val = distance;
            got.cx       = closest_x;
            got.cy       = closest_y;
            got.cz       = closest_z;
            sb.check(got);
        end
        // watchdog: any accepted transaction on either side restarts it
        if (!rst_n || (start && !busy) || done)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("watchdog expired with %0d results outstanding", sb.outstanding());
            $display("tb_segment_segment_closest_distance: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // present one query and hold it until the accepting edge
    task send(query_t q);
        fsx <= q.pt[0];  fsy <= q.pt[1];  fsz <= q.pt[2];
        fex <= q.pt[3];  fey <= q.pt[4];  fez <= q.pt[5];
        ssx <= q.pt[6];  ssy <= q.pt[7];  ssz <= q.pt[8];
        sex <= q.pt[9];  sey <= q.pt[10]; sez <= q.pt[11];
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy_s);
        sb.note(q);
    endtask

    task idle(int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // short random gap between bursts, sometimes none at all
    int burst_left = 0;

    task pace();
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 80)
                                               : $urandom_range(1, 12);
        if ($urandom_range(0, 4) != 0)
            idle($urandom_range(1, 9));
    endtask

    function automatic ssd_pkg::coord_t rand_coord(int span);
        if (span >= 32768)
            return ssd_pkg::coord_t'($urandom());
        return ssd_pkg::coord_t'($urandom_range(0, 2 * span) - span);
    endfunction

    // random query, sometimes shaped toward one of the interesting configurations
    int n_parallel = 0;
    int n_degenerate = 0;

    function automatic query_t random_query();
        query_t q;
        int span;
        int k;
        int shape;
        shape = $urandom_range(0, 9);
        case ($urandom_range(0, 3))
            0: span = 32768;
            1: span = 4096;
            2: span = 512;
            default: span = 16;
        endcase
        for (int i = 0; i < 12; i++)
            q.pt[i] = rand_coord(span);
        case (shape)
            0, 1:
            begin
                // parallel or antiparallel: second direction is a multiple of the first
                k = $urandom_range(0, 6) - 3;
                for (int i = 0; i < 3; i++)
                    q.pt[9 + i] = q.pt[6 + i]
                                + ssd_pkg::coord_t'(k * (q.pt[3 + i] - q.pt[i]));
                n_parallel++;
            end
            2:
            begin
                // per axis, the first or the second segment is flattened; a point when all three pick the same one
                for (int i = 0; i < 3; i++)
                    if ($urandom_range(0, 1)) q.pt[3 + i] = q.pt[i];
                    else q.pt[9 + i] = q.pt[6 + i];
                n_degenerate++;
            end
            3:
            begin
                // shared endpoint
                for (int i = 0; i < 3; i++)
                    q.pt[6 + i] = q.pt[3 + i];
            end
            default: ;
        endcase
        return q;
    endfunction

    query_t directed_q[$];

    task load_directed();
        query_t q;
        q.pt = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};                 directed_q.push_back(q);
        // extreme corners: full-range spans, corner points, full-width parallel spans
        q.pt = '{-32768, -32768, -32768, 32767, 32767, 32767,
                 32767, -32768, 32767, -32768, 32767, -32768};         directed_q.push_back(q);
        q.pt = '{32767, 32767, 32767, 32767, 32767, 32767,
                 -32768, -32768, -32768, -32768, -32768, -32768};     directed_q.push_back(q);
        q.pt = '{-32768, 0, 0, 32767, 0, 0, -32768, 0, 256, 32767, 0, 256};
                                                                       directed_q.push_back(q);
        // degenerate first, degenerate second
        q.pt = '{256, 256, 256, 256, 256, 256, 0, 0, 0, 512, 0, 0};   directed_q.push_back(q);
        q.pt = '{0, 0, 0, 512, 0, 0, 256, 256, 0, 256, 256, 0};       directed_q.push_back(q);
        // parallel: overlapping collinear, disjoint, antiparallel
        q.pt = '{0, 0, 0, 1024, 0, 0, 512, 0, 0, 2048, 0, 0};         directed_q.push_back(q);
        q.pt = '{0, 0, 0, 256, 0, 0, 1024, 256, 0, 2048, 256, 0};     directed_q.push_back(q);
        q.pt = '{0, 0, 0, 256, 0, 0, 2048, 256, 0, 1024, 256, 0};     directed_q.push_back(q);
        q.pt = '{0, 0, 0, 256, 0, 0, -1024, 256, 0, -2048, 256, 0};   directed_q.push_back(q);
        // crossing and skew, interior solution
        q.pt = '{-256, 0, 0, 256, 0, 0, 0, -256, 0, 0, 256, 0};       directed_q.push_back(q);
        q.pt = '{-256, 0, 0, 256, 0, 0, 0, -256, 300, 0, 256, 300};   directed_q.push_back(q);
        // s clamped low / high, t clamped low / high
        q.pt = '{100, 0, 0, 500, 0, 0, 0, -256, 50, 0, 256, 50};      directed_q.push_back(q);
        q.pt = '{-500, 0, 0, -100, 0, 0, 0, -256, 50, 0, 256, 50};    directed_q.push_back(q);
        q.pt = '{-256, 0, 0, 256, 0, 0, 0, 100, 50, 0, 600, 50};      directed_q.push_back(q);
        q.pt = '{-256, 0, 0, 256, 0, 0, 0, -600, 50, 0, -100, 50};    directed_q.push_back(q);
        // both clamped at corners
        q.pt = '{-900, -900, 0, -500, -500, 0, 500, 900, 7, 900, 500, 7};
                                                                       directed_q.push_back(q);
        // single lsb steps
        q.pt = '{0, 0, 0, 1, 0, 0, 0, 1, 1, 0, 1, 2};                 directed_q.push_back(q);
        q.pt = '{-1, -1, -1, 1, 1, 1, 1, -1, 1, -1, 1, -1};           directed_q.push_back(q);
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        {fsx, fsy, fsz, fex, fey, fez} = '0;
        {ssx, ssy, ssz, sex, sey, sez} = '0;
        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        load_directed();
        foreach (directed_q[i])
        begin
            send(directed_q[i]);
            pace();
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            send(random_query());
            pace();
            // drain the pipeline completely once mid-run
            if (n == N_RANDOM / 2)
            begin
                start <= 1'b0;
                while (sb.outstanding() != 0)
                    @(posedge clk);
            end
        end
        start <= 1'b0;

        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (ssd_pkg::LATENCY + 10) @(posedge clk);

        $display("covered %0d queries: %0d directed, %0d random",
                 sb.noted, directed_q.size(), N_RANDOM);
        $display("  (%0d parallel, %0d degenerate), checked %0d results, %0d mismatches",
                 n_parallel, n_degenerate, sb.checked, fail_count);
        if (fail_count == 0)
            $display("tb_segment_segment_closest_distance: PASS");
        else
            $display("tb_segment_segment_closest_distance: FAIL");
        $finish;
    end

endmodule
